@@ rtl/core/lrsc_pkg.sv @@
// Shared types, codes and helpers for the label raster stream converter.
`timescale 1ns / 1ps
package lrsc_pkg;

    localparam int LINE_STORE_BYTES_DEF = 64;
    localparam int QUEUE_DEPTH          = 4;

    // stream codes
    localparam logic [7:0] ESC_CODE = 8'd27;
    localparam logic [7:0] ETB_CODE = 8'd23;
    localparam logic [7:0] SYN_CODE = 8'd22;

    // command letters
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] SKIP_ONE = 8'h01;

    localparam logic [8:0]  NONE_SENT = 9'h1FF;
    localparam logic [11:0] POS_MAX   = 12'hFFF;

    // resample ratio 136/203
    localparam logic [8:0] RS_NUM = 9'd136;
    localparam logic [8:0] RS_DEN = 9'd203;

    typedef enum logic [3:0] {
        PS_IDLE, PS_CMD, PS_ARG_B, PS_ARG_D, PS_FWD, PS_RLE, PS_RAW
    } parse_state_t;

    typedef enum logic [2:0] {
        OP_ESC_CMD, OP_ARG, OP_BEGIN, OP_RLE, OP_RAW
    } job_op_t;

    typedef struct packed {
        job_op_t    op;
        logic [7:0] data;
        logic       fin;
    } job_t;

    typedef enum logic [3:0] {
        BS_IDLE, BS_ESC, BS_ARG, BS_PLACE, BS_FIN, BS_LOAD, BS_BIT, BS_TAIL,
        BS_DECIDE, BS_FSKIP, BS_SETB, BS_SETD, BS_SYN, BS_RD, BS_DATA
    } back_state_t;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/lrsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lrsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/lrsc_front.sv @@
// Command parser: classifies input bytes and posts jobs to the back end.
`timescale 1ns / 1ps
module lrsc_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_data,
    input  logic          q_full,
    output logic          job_valid,
    output lrsc_pkg::job_t job
);
    import lrsc_pkg::*;

    parse_state_t state_reg, state_next;
    logic [1:0]   pend_reg, pend_next;
    logic [7:0]   tab_reg, tab_next;
    logic [7:0]   lb_reg, lb_next;
    logic [11:0]  prog_reg, prog_next;

    logic        accept;
    logic [11:0] prog_rle, prog_raw;
    logic        end_rle, end_raw, zero_len;
    logic [1:0]  pend_dec;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign prog_rle = prog_reg + {5'b0, in_data[6:0]} + 12'd1;
    assign prog_raw = prog_reg + 12'd1;
    assign end_rle  = prog_rle >= {1'b0, lb_reg, 3'b000};
    assign end_raw  = prog_raw >= {4'b0, lb_reg};
    assign zero_len = lb_reg == 8'd0;
    assign pend_dec = (pend_reg == 2'd0) ? 2'd0 : pend_reg - 2'd1;

    // next state
    always_comb begin
        state_next = state_reg;
        if (accept) begin
            unique case (state_reg)
                PS_CMD: begin
                    unique case (in_data) inside
                        CH_B:                     state_next = PS_ARG_B;
                        CH_D:                     state_next = PS_ARG_D;
                        CH_Q, CH_L, CH_W, CH_F,
                        CH_R:                     state_next = PS_FWD;
                        default:                  state_next = PS_IDLE;
                    endcase
                end
                PS_ARG_B, PS_ARG_D: state_next = PS_IDLE;
                PS_FWD:   if (pend_dec == 2'd0) state_next = PS_IDLE;
                PS_RLE:   if (end_rle) state_next = PS_IDLE;
                PS_RAW:   if (end_raw) state_next = PS_IDLE;
                default: begin
                    if (in_data == ESC_CODE) begin
                        state_next = PS_CMD;
                    end else if (in_data == ETB_CODE) begin
                        state_next = zero_len ? PS_IDLE : PS_RLE;
                    end else if (in_data == SYN_CODE) begin
                        state_next = zero_len ? PS_IDLE : PS_RAW;
                    end else begin
                        state_next = PS_IDLE;
                    end
                end
            endcase
        end
    end

    // job and settings
    always_comb begin
        pend_next = pend_reg;
        tab_next  = tab_reg;
        lb_next   = lb_reg;
        prog_next = prog_reg;
        job_valid = 1'b0;
        job.op    = OP_ARG;
        job.data  = in_data;
        job.fin   = 1'b0;
        if (accept) begin
            unique case (state_reg)
                PS_CMD: begin
                    unique case (in_data) inside
                        CH_Q, CH_L, CH_W, CH_F: begin
                            job_valid = 1'b1;
                            job.op    = OP_ESC_CMD;
                            pend_next = 2'd2;
                        end
                        CH_R: begin
                            job_valid = 1'b1;
                            job.op    = OP_ESC_CMD;
                            pend_next = 2'd1;
                        end
                        CH_E, CH_A, CH_LA, CH_AT, CH_STAR, CH_V: begin
                            job_valid = 1'b1;
                            job.op    = OP_ESC_CMD;
                        end
                        default: ;
                    endcase
                end
                PS_ARG_B: tab_next = in_data;
                PS_ARG_D: lb_next  = in_data;
                PS_FWD: begin
                    job_valid = 1'b1;
                    job.op    = OP_ARG;
                    pend_next = pend_dec;
                end
                PS_RLE: begin
                    job_valid = 1'b1;
                    job.op    = OP_RLE;
                    job.fin   = end_rle;
                    prog_next = prog_rle;
                end
                PS_RAW: begin
                    job_valid = 1'b1;
                    job.op    = OP_RAW;
                    job.fin   = end_raw;
                    prog_next = prog_raw;
                end
                default: begin
                    if (in_data == ETB_CODE || in_data == SYN_CODE) begin
                        job_valid = 1'b1;
                        job.op    = OP_BEGIN;
                        job.data  = tab_reg;
                        job.fin   = zero_len;
                        prog_next = 12'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PS_IDLE;
            pend_reg  <= 2'd0;
            tab_reg   <= 8'd0;
            lb_reg    <= 8'd56;
            prog_reg  <= 12'd0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            tab_reg   <= tab_next;
            lb_reg    <= lb_next;
            prog_reg  <= prog_next;
        end
    end
endmodule

@@ rtl/core/lrsc_queue.sv @@
// Short job queue between the parser and the line engine.
`timescale 1ns / 1ps
module lrsc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lrsc_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output lrsc_pkg::job_t head
);
    import lrsc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          slots [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = cnt_reg == CW'(QUEUE_DEPTH);
    assign valid = cnt_reg != '0;
    assign head  = slots[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wp_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule

@@ rtl/core/lrsc_back.sv @@
// Line engine: places raster bits, resamples, trims and emits output bytes.
`timescale 1ns / 1ps
module lrsc_back #(
    parameter int LINE_STORE_BYTES = lrsc_pkg::LINE_STORE_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  lrsc_pkg::job_t q_job,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);
    import lrsc_pkg::*;

    localparam int AW = $clog2(LINE_STORE_BYTES);
    localparam int SW = AW + 4;
    localparam logic [11:0] STORE_BITS = 12'(LINE_STORE_BYTES * 8);

    back_state_t state_reg, state_next;

    logic [7:0]    jdata_reg, jdata_next;
    logic          fin_reg, fin_next;
    logic [7:0]    tab_reg, tab_next;
    logic [11:0]   wpos_reg, wpos_next;
    logic [7:0]    acc_reg, acc_next;
    logic [7:0]    rem_reg, rem_next;
    logic [7:0]    sr_reg, sr_next;
    logic          fill_reg, fill_next;
    logic          raw_reg, raw_next;
    logic [SW-1:0] nbits_reg, nbits_next;
    logic [SW-1:0] src_reg, src_next;
    logic [7:0]    r_reg, r_next;
    logic [8:0]    d_reg, d_next;
    logic [7:0]    dacc_reg, dacc_next;
    logic          dpend_reg, dpend_next;
    logic [AW-1:0] db_reg, db_next;
    logic          nz_reg, nz_next;
    logic [AW-1:0] first_reg, first_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [1:0]    phase_reg, phase_next;
    logic [8:0]    pskip_reg, pskip_next;
    logic [8:0]    pcount_reg, pcount_next;
    logic          ov_reg;
    logic [7:0]    od_reg;
    logic          ol_reg;

    // placement helpers
    logic [2:0]  o;
    logic [3:0]  room, k;
    logic        beyond, full_byte;
    logic [12:0] sum13;
    logic [7:0]  mask, rem_after;
    logic [2:0]  bitpos;

    // walk helpers
    logic [8:0]  bytes9;
    logic [AW:0] nbytes;
    logic [7:0]  sbyte, dacc_t;
    logic        taken, bitv, wrap;
    logic [8:0]  rs;
    logic [SW-1:0] src_inc;
    logic [AW:0] count;

    // memories
    logic          st_we, res_we;
    logic [AW-1:0] st_wa, res_wa;
    logic [7:0]    st_wd, res_wd, st_rd, res_rd;

    logic       out_can, emit_req, emit_en, emit_last;
    logic [7:0] emit_byte;

    assign out_can = !ov_reg || m_tready;
    assign q_pop   = (state_reg == BS_IDLE) && q_valid;

    always_comb begin
        o         = wpos_reg[2:0];
        room      = 4'd8 - {1'b0, o};
        k         = (rem_reg < {4'b0, room}) ? rem_reg[3:0] : room;
        beyond    = wpos_reg >= STORE_BITS;
        sum13     = {1'b0, wpos_reg} + {5'b0, rem_reg};
        rem_after = rem_reg - {4'b0, k};
        full_byte = ({1'b0, o} + k) == 4'd8;
        mask      = 8'd0;
        for (int t = 0; t < 8; t++) begin
            bitpos = o + 3'(t);
            if (4'(t) < k) begin
                mask[bitpos] = raw_reg ? sr_reg[7 - t] : fill_reg;
            end
        end
    end

    always_comb begin
        bytes9  = wpos_reg[11:3];
        nbytes  = (bytes9 > 9'(LINE_STORE_BYTES)) ? (AW + 1)'(LINE_STORE_BYTES)
                                                   : bytes9[AW:0];
        sbyte   = (8'(src_reg[SW-1:3]) >= tab_reg) ? st_rd : 8'd0;
        bitv    = sbyte[src_reg[2:0]];
        taken   = r_reg < RS_NUM[7:0];
        dacc_t  = dacc_reg | (8'(bitv) << d_reg[2:0]);
        rs      = {1'b0, r_reg} + RS_NUM;
        wrap    = rs >= RS_DEN;
        src_inc = src_reg + 1'b1;
        count   = {1'b0, last_reg} - {1'b0, first_reg} + 1'b1;
    end

    always_comb begin
        st_we  = (state_reg == BS_PLACE) && !beyond && full_byte;
        st_wa  = wpos_reg[3 +: AW];
        st_wd  = acc_reg | mask;
        res_we = 1'b0;
        res_wa = d_reg[3 +: AW];
        res_wd = dacc_t;
        if (state_reg == BS_BIT) begin
            res_we = taken && (d_reg[2:0] == 3'd7);
        end else if (state_reg == BS_TAIL) begin
            res_we = dpend_reg;
            res_wa = db_reg;
            res_wd = dacc_reg;
        end
    end

    lrsc_ram #(.WIDTH(8), .DEPTH(LINE_STORE_BYTES)) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_wa),
        .wdata (st_wd),
        .raddr (src_reg[AW+2:3]),
        .rdata (st_rd)
    );

    lrsc_ram #(.WIDTH(8), .DEPTH(LINE_STORE_BYTES)) u_result (
        .aclk  (aclk),
        .we    (res_we),
        .waddr (res_wa),
        .wdata (res_wd),
        .raddr (idx_reg),
        .rdata (res_rd)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE: begin
                if (q_valid) begin
                    unique case (q_job.op)
                        OP_ESC_CMD:      state_next = BS_ESC;
                        OP_ARG:          state_next = BS_ARG;
                        OP_BEGIN:        state_next = q_job.fin ? BS_FIN : BS_IDLE;
                        OP_RLE, OP_RAW:  state_next = BS_PLACE;
                        default:         state_next = BS_IDLE;
                    endcase
                end
            end
            BS_ESC:   if (out_can) state_next = BS_ARG;
            BS_ARG:   if (out_can) state_next = BS_IDLE;
            BS_PLACE: begin
                if (beyond || rem_after == 8'd0) begin
                    state_next = fin_reg ? BS_FIN : BS_IDLE;
                end
            end
            BS_FIN:   state_next = (nbytes == '0) ? BS_DECIDE : BS_LOAD;
            BS_LOAD:  state_next = BS_BIT;
            BS_BIT: begin
                if (src_inc == nbits_reg)       state_next = BS_TAIL;
                else if (src_inc[2:0] == 3'd0)  state_next = BS_LOAD;
            end
            BS_TAIL:  state_next = BS_DECIDE;
            BS_DECIDE: begin
                if (!nz_reg)                               state_next = BS_FSKIP;
                else if (9'(first_reg) != pskip_reg)       state_next = BS_SETB;
                else if (9'(count) != pcount_reg)          state_next = BS_SETD;
                else                                       state_next = BS_SYN;
            end
            BS_FSKIP: if (out_can && phase_reg == 2'd3) state_next = BS_IDLE;
            BS_SETB: begin
                if (out_can && phase_reg == 2'd2) begin
                    state_next = (9'(count) != pcount_reg) ? BS_SETD : BS_SYN;
                end
            end
            BS_SETD:  if (out_can && phase_reg == 2'd2) state_next = BS_SYN;
            BS_SYN:   if (out_can) state_next = BS_RD;
            BS_RD:    state_next = BS_DATA;
            BS_DATA: begin
                if (out_can) state_next = (idx_reg == last_reg) ? BS_IDLE : BS_RD;
            end
            default:  state_next = BS_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        jdata_next  = jdata_reg;
        fin_next    = fin_reg;
        tab_next    = tab_reg;
        wpos_next   = wpos_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        sr_next     = sr_reg;
        fill_next   = fill_reg;
        raw_next    = raw_reg;
        nbits_next  = nbits_reg;
        src_next    = src_reg;
        r_next      = r_reg;
        d_next      = d_reg;
        dacc_next   = dacc_reg;
        dpend_next  = dpend_reg;
        db_next     = db_reg;
        nz_next     = nz_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        pskip_next  = pskip_reg;
        pcount_next = pcount_reg;
        unique case (state_reg)
            BS_IDLE: begin
                if (q_valid) begin
                    jdata_next = q_job.data;
                    fin_next   = q_job.fin;
                    case (q_job.op)
                        OP_BEGIN: begin
                            tab_next  = q_job.data;
                            wpos_next = {1'b0, q_job.data, 3'b000};
                            acc_next  = 8'd0;
                        end
                        OP_RLE: begin
                            rem_next  = {1'b0, q_job.data[6:0]} + 8'd1;
                            fill_next = q_job.data[7];
                            raw_next  = 1'b0;
                        end
                        OP_RAW: begin
                            rem_next = 8'd8;
                            sr_next  = q_job.data;
                            raw_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            BS_PLACE: begin
                if (beyond) begin
                    wpos_next = (sum13 > {1'b0, POS_MAX}) ? POS_MAX : sum13[11:0];
                    rem_next  = 8'd0;
                end else begin
                    wpos_next = wpos_reg + 12'(k);
                    rem_next  = rem_after;
                    sr_next   = sr_reg << k;
                    acc_next  = full_byte ? 8'd0 : (acc_reg | mask);
                end
            end
            BS_FIN: begin
                nbits_next = {nbytes, 3'b000};
                src_next   = '0;
                r_next     = 8'd0;
                d_next     = 9'd0;
                dacc_next  = 8'd0;
                dpend_next = 1'b0;
                nz_next    = 1'b0;
            end
            BS_BIT: begin
                if (taken) begin
                    db_next = d_reg[3 +: AW];
                    if (d_reg[2:0] == 3'd7) begin
                        dacc_next  = 8'd0;
                        dpend_next = 1'b0;
                    end else begin
                        dacc_next  = dacc_t;
                        dpend_next = 1'b1;
                    end
                end
                r_next   = wrap ? 8'(rs - RS_DEN) : rs[7:0];
                d_next   = wrap ? d_reg + 9'd1 : d_reg;
                src_next = src_inc;
            end
            BS_DECIDE: phase_next = 2'd0;
            BS_FSKIP: if (out_can) phase_next = phase_reg + 2'd1;
            BS_SETB: begin
                if (out_can) begin
                    phase_next = phase_reg + 2'd1;
                    if (phase_reg == 2'd2) begin
                        pskip_next = 9'(first_reg);
                        phase_next = 2'd0;
                    end
                end
            end
            BS_SETD: begin
                if (out_can) begin
                    phase_next = phase_reg + 2'd1;
                    if (phase_reg == 2'd2) begin
                        pcount_next = 9'(count);
                        phase_next  = 2'd0;
                    end
                end
            end
            BS_SYN:  if (out_can) idx_next = first_reg;
            BS_DATA: if (out_can && idx_reg != last_reg) idx_next = idx_reg + 1'b1;
            default: ;
        endcase
        // trim bounds follow every nonzero result byte written
        if (res_we && res_wd != 8'd0) begin
            if (!nz_reg) first_next = res_wa;
            last_next = res_wa;
            nz_next   = 1'b1;
        end
    end

    // output byte selection
    always_comb begin
        emit_req  = 1'b0;
        emit_byte = ESC_CODE;
        emit_last = 1'b0;
        unique case (state_reg)
            BS_ESC: emit_req = 1'b1;
            BS_ARG: begin
                emit_req  = 1'b1;
                emit_byte = jdata_reg;
                emit_last = 1'b1;
            end
            BS_FSKIP: begin
                emit_req  = 1'b1;
                emit_last = phase_reg == 2'd3;
                case (phase_reg)
                    2'd0:    emit_byte = ESC_CODE;
                    2'd1:    emit_byte = CH_F;
                    2'd2:    emit_byte = CH_ONE;
                    default: emit_byte = SKIP_ONE;
                endcase
            end
            BS_SETB: begin
                emit_req = 1'b1;
                case (phase_reg)
                    2'd0:    emit_byte = ESC_CODE;
                    2'd1:    emit_byte = CH_B;
                    default: emit_byte = 8'(first_reg);
                endcase
            end
            BS_SETD: begin
                emit_req = 1'b1;
                case (phase_reg)
                    2'd0:    emit_byte = ESC_CODE;
                    2'd1:    emit_byte = CH_D;
                    default: emit_byte = 8'(count);
                endcase
            end
            BS_SYN: begin
                emit_req  = 1'b1;
                emit_byte = SYN_CODE;
            end
            BS_DATA: begin
                emit_req  = 1'b1;
                emit_byte = flip8(res_rd);
                emit_last = idx_reg == last_reg;
            end
            default: ;
        endcase
        emit_en = emit_req && out_can;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BS_IDLE;
            ov_reg     <= 1'b0;
            pskip_reg  <= NONE_SENT;
            pcount_reg <= NONE_SENT;
            nz_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pskip_reg  <= pskip_next;
            pcount_reg <= pcount_next;
            nz_reg     <= nz_next;
            if (emit_en)       ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_en) begin
            od_reg <= emit_byte;
            ol_reg <= emit_last;
        end
        jdata_reg <= jdata_next;
        fin_reg   <= fin_next;
        tab_reg   <= tab_next;
        wpos_reg  <= wpos_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        sr_reg    <= sr_next;
        fill_reg  <= fill_next;
        raw_reg   <= raw_next;
        nbits_reg <= nbits_next;
        src_reg   <= src_next;
        r_reg     <= r_next;
        d_reg     <= d_next;
        dacc_reg  <= dacc_next;
        dpend_reg <= dpend_next;
        db_reg    <= db_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        idx_reg   <= idx_next;
        phase_reg <= phase_next;
    end
endmodule

@@ rtl/core/label_raster_stream_converter_top.sv @@
// Top level of the label raster stream converter.
//
//  channel | dir | tdata                | tuser | tlast
//  s_      | in  | [7:0] in_byte        | -     | -
//  m_      | out | [7:0] out_byte       | -     | last_of_run
//
// The parser takes one byte per cycle while its 4-entry job queue has room.
// The line engine takes each job from the queue while idle, emits each output
// byte of a forwarded command or argument, places a run or raw byte one store
// byte at a time (a 128-bit run touches up to 17), and at line end walks each
// stored byte bit by bit for the resample, then reads and emits each data byte.
// No clearing pass after reset: untouched store bytes are masked by the dot tab.
// Either side may stall on its own; the output register holds a transfer.
`timescale 1ns / 1ps
module label_raster_stream_converter_top #(
    parameter int LINE_STORE_BYTES = lrsc_pkg::LINE_STORE_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // last_of_run
);
    import lrsc_pkg::*;

    logic q_push, q_full, q_pop, q_valid;
    job_t push_job, head_job;

    // front: command parsing, dot tab and line length settings
    lrsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .q_full    (q_full),
        .job_valid (q_push),
        .job       (push_job)
    );

    lrsc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_job)
    );

    // back: line placement, resample, trim and output
    lrsc_back #(.LINE_STORE_BYTES(LINE_STORE_BYTES)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("job popped from empty queue");

    a_ready_tracks_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !q_push) |=> s_tready)
        else $error("input stalled after a queue slot freed");
`endif
endmodule
